// ===== rtl/aes_pkg.sv =====
// AES-128 package: S-box table, GF(2^8) helpers and round/key step functions.
// No dependencies; used by aes_round and aes128_block_encrypt.
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam logic [7:0]  GfReduce   = 8'h1b;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  typedef logic [127:0] block_t;

  typedef struct packed {
    block_t st;
    block_t rk;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfReduce : 8'h00);
  endfunction

  function automatic logic [7:0] times_three(input logic [7:0] v);
    return gf_double(v) ^ v;
  endfunction

  // round constant used when producing the key of round r (1..10)
  function automatic logic [7:0] rcon_of(input int unsigned r);
    logic [7:0] c;
    c = 8'h01;
    for (int unsigned i = 1; i < r; i++) c = gf_double(c);
    return c;
  endfunction

  // byte n of a block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input block_t b, input int unsigned n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic block_t next_key(input block_t rk, input logic [7:0] rc);
    logic [7:0] k [16];
    block_t     r;
    for (int unsigned n = 0; n < 16; n++) k[n] = byte_of(rk, n);
    k[0] = k[0] ^ SBOX[k[13]] ^ rc;
    k[1] = k[1] ^ SBOX[k[14]];
    k[2] = k[2] ^ SBOX[k[15]];
    k[3] = k[3] ^ SBOX[k[12]];
    for (int unsigned n = 4; n < 16; n++) k[n] = k[n] ^ k[n-4];
    for (int unsigned n = 0; n < 16; n++) r[127 - 8*n -: 8] = k[n];
    return r;
  endfunction

  function automatic block_t round_fn(input block_t st, input block_t rk,
                                      input logic mix);
    logic [7:0] t [16];
    logic [7:0] a, b, c, d;
    block_t     r;
    for (int unsigned n = 0; n < 16; n++)
      t[(n + 16 - 4*(n % 4)) % 16] = SBOX[byte_of(st, n)];
    if (mix) begin
      for (int unsigned col = 0; col < 16; col += 4) begin
        a = t[col]; b = t[col+1]; c = t[col+2]; d = t[col+3];
        t[col]   = a ^ times_three(a ^ b) ^ c ^ d;
        t[col+1] = b ^ times_three(b ^ c) ^ a ^ d;
        t[col+2] = c ^ times_three(c ^ d) ^ a ^ b;
        t[col+3] = d ^ times_three(a ^ d) ^ b ^ c;
      end
    end
    for (int unsigned n = 0; n < 16; n++) r[127 - 8*n -: 8] = t[n] ^ byte_of(rk, n);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_round.sv =====
// One pipelined AES round: key step plus SubBytes/ShiftRows/MixColumns (not in round 10)/AddRoundKey.
// Depends on aes_pkg.
`default_nettype none
module aes_round #(
  parameter int unsigned ROUND = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  aes_pkg::stage_t      in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output aes_pkg::stage_t      out_data,
  input  wire logic            out_ready
);
  import aes_pkg::*;

  localparam logic [7:0] Rcon    = rcon_of(ROUND);
  localparam logic       DoMix   = (ROUND != RoundCount);

  block_t key_next;

  assign in_ready = !out_valid || out_ready;
  assign key_next = next_key(in_data.rk, Rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.rk <= key_next;
      out_data.st <= round_fn(in_data.st, key_next, DoMix);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aes128_block_encrypt.sv =====
// AES-128 ECB encryption top level: key registers, initial AddRoundKey stage
// and ten aes_round stages. Depends on aes_pkg and aes_round.
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  plain    | in_valid, in_stall, plain_high, plain_low | in
//  cipher   | out_valid, out_stall, cipher_high/low     | out
//  config   | cfg_write, cfg_index, cfg_data            | in
//
// Throughput: one block per cycle unless stalled. Whitening stage plus one
// register stage per round, each an S-box layer; MixColumns in rounds 1-9 only.
// Round keys travel with each block, so a key write affects later blocks only.
// Each stage holds while its successor is full and stalled; empty stages are
// filled, so bubbles collapse. Synchronous reset clears valids and the key.
`default_nettype none
module aes128_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] plain_high,
  input  wire logic [63:0] plain_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      cipher_high,
  output logic [63:0]      cipher_low
);
  import aes_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;

  // stage 0 is whitening, stage r holds the output of round r;
  // ready[r] (r >= 1): stage r may take a transfer from stage r-1
  logic   valid [RoundCount+1];
  stage_t data  [RoundCount+1];
  logic   ready [RoundCount+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      if (cfg_index == REG_KEY_LOW)  key_low  <= cfg_data;
    end
  end

  assign ready[0] = !valid[0] || ready[1];
  assign in_stall = !ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (ready[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      data[0].rk <= {key_high, key_low};
      data[0].st <= {plain_high, plain_low} ^ {key_high, key_low};
    end
  end

  for (genvar r = 1; r <= RoundCount; r++) begin : g_round
    logic rdy_out;
    aes_round #(.ROUND(r)) u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid[r-1]),
      .in_data  (data[r-1]),
      .in_ready (ready[r]),
      .out_valid(valid[r]),
      .out_data (data[r]),
      .out_ready(rdy_out)
    );
    if (r < RoundCount) begin : g_mid
      assign rdy_out = ready[r+1];
    end else begin : g_last
      assign rdy_out = !out_stall;
    end
  end

  assign out_valid   = valid[RoundCount];
  assign cipher_high = data[RoundCount].st[127:64];
  assign cipher_low  = data[RoundCount].st[63:0];

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid[0])
    else $error("accepted block did not enter first stage");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid[0])
    else $error("input stalled with empty first stage");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cipher_low)))
    else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_aes128_block_encrypt.sv =====
// Self-checking testbench for aes128_block_encrypt (AES-128 ECB encryption).
// Depends on aes_pkg (register indexes) and the aes128_block_encrypt RTL.
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;
  import aes_pkg::*;

  // cfg_index is two bits wide; these two indexes decode to no register
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned DrainCycles = 16;   // pipeline is 11 deep

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic [63:0] plain_high, plain_low;
  logic        out_valid, out_stall;
  logic [63:0] cipher_high, cipher_low;

  aes128_block_encrypt i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .plain_high(plain_high), .plain_low(plain_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .cipher_high(cipher_high), .cipher_low(cipher_low)
  );

  // Mirror of the key registers and the queue of ciphertexts still owed
  logic [63:0]  key_hi, key_lo;
  logic [127:0] cipher_q[$];
  logic [7:0]   sbox_tab[256];
  bit           idle_on;
  int unsigned  err_count, blocks_sent, blocks_checked, key_writes;
  int unsigned  stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: S-box derived from the GF(2^8) inverse and the affine map, so
  // it shares nothing with the RTL's table.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic void build_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_tab[x] = s;
    end
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                               input logic [127:0] pt);
    logic [7:0] s[16], t[16], k[16];
    logic [7:0] rc, a, b, c, d, r0, r1, r2, r3;
    logic [127:0] ct;
    for (int n = 0; n < 16; n++) begin
      k[n] = key[127 - 8*n -: 8];
      s[n] = pt[127 - 8*n -: 8] ^ k[n];
    end
    rc = 8'h01;
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // key schedule: rotate, substitute, add round constant, chain words
      r0 = sbox_tab[k[13]]; r1 = sbox_tab[k[14]];
      r2 = sbox_tab[k[15]]; r3 = sbox_tab[k[12]];
      k[0] ^= r0 ^ rc; k[1] ^= r1; k[2] ^= r2; k[3] ^= r3;
      for (int n = 4; n < 16; n++) k[n] ^= k[n-4];
      rc = xtime(rc);
      // substitute and shift rows (row = n mod 4, column moves left by row)
      for (int n = 0; n < 16; n++) t[(n + 16 - 4*(n % 4)) % 16] = sbox_tab[s[n]];
      if (rnd != 10) begin
        for (int col = 0; col < 16; col += 4) begin
          a = t[col]; b = t[col+1]; c = t[col+2]; d = t[col+3];
          t[col]   = gf_mul(a, 8'h02) ^ gf_mul(b, 8'h03) ^ c ^ d;
          t[col+1] = a ^ gf_mul(b, 8'h02) ^ gf_mul(c, 8'h03) ^ d;
          t[col+2] = a ^ b ^ gf_mul(c, 8'h02) ^ gf_mul(d, 8'h03);
          t[col+3] = gf_mul(a, 8'h03) ^ b ^ c ^ gf_mul(d, 8'h02);
        end
      end
      for (int n = 0; n < 16; n++) s[n] = t[n] ^ k[n];
    end
    for (int n = 0; n < 16; n++) ct[127 - 8*n -: 8] = s[n];
    return ct;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // One plaintext transfer; in_valid is left high so a following call
  // streams back to back.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    plain_high <= hi;
    plain_low  <= lo;
    do @(posedge clk); while (in_stall);
    cipher_q.push_back(aes_encrypt({key_hi, key_lo}, {hi, lo}));
    blocks_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Key writes only with the pipeline empty
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wait_drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi = val;
    else if (idx == REG_KEY_LOW) key_lo = val;
    key_writes++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, and the result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("transfer with nothing owed", cipher_high, 64'h0);
      end else begin
        want = cipher_q.pop_front();
        if (cipher_high !== want[127:64])
          report_mismatch("cipher_high", cipher_high, want[127:64]);
        if (cipher_low !== want[63:0])
          report_mismatch("cipher_low", cipher_low, want[63:0]);
        blocks_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No key written yet: all-zero key, extreme plaintexts
  task automatic test_reset_key();
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    end_burst();
  endtask

  // Standard published vector; also proves the predictor itself
  task automatic test_known_vector();
    logic [127:0] ct;
    ct = aes_encrypt(128'h000102030405060708090a0b0c0d0e0f,
                     128'h00112233445566778899aabbccddeeff);
    if (ct !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a)
      report_mismatch("predictor vector", ct[127:64], 64'h69c4e0d86a7b0430);
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    end_burst();
  endtask

  // Key extremes, and writes to undecoded indexes that must change nothing
  task automatic test_key_extremes();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW,  '1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    end_burst();
    write_reg(REG_SPARE_A, 64'h0);
    write_reg(REG_SPARE_B, 64'h1234_5678_9abc_def0);
    send_block(64'h0, '1);
    end_burst();
    write_reg(REG_KEY_HIGH, 64'h0);
    send_block('1, 64'h0);
    end_burst();
  endtask

  // Random keys and blocks under random idling on both sides
  task automatic test_random_stream(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        end_burst();
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW,  rand64());
      end
      send_block(rand64(), rand64());
    end
    end_burst();
  endtask

  // Sender holds off until the whole pipeline has emptied, then resumes
  task automatic test_drain_pause();
    for (int unsigned i = 0; i < 20; i++) send_block(rand64(), rand64());
    end_burst();
    while (cipher_q.size() != 0) @(posedge clk);
    for (int unsigned i = 0; i < 20; i++) send_block(rand64(), rand64());
    end_burst();
  endtask

  // Full-rate streaming with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    write_reg(REG_KEY_LOW, rand64());
    for (int unsigned i = 0; i < 80; i++) send_block(rand64(), rand64());
    end_burst();
  endtask

  initial begin
    rst = 1'b1; cfg_write = 1'b0; cfg_index = REG_KEY_HIGH; cfg_data = '0;
    in_valid = 1'b0; plain_high = '0; plain_low = '0;
    key_hi = '0; key_lo = '0; idle_on = 1'b1;
    err_count = 0; blocks_sent = 0; blocks_checked = 0; key_writes = 0;
    build_sbox();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_known_vector();
    test_key_extremes();
    test_random_stream(460);
    test_drain_pause();
    test_full_rate();

    wait_drain();
    $display("Covered %0d blocks, %0d checked, %0d key writes incl. undecoded indexes,",
             blocks_sent, blocks_checked, key_writes);
    $display("zero/all-ones keys and data, random stalls, drain pause, full rate.");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", cipher_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
